@@ sv/rcr_pkg.sv @@
// ----------------------------------------------------------------------------
// rcr_pkg
// Shared constants, types and the sine table generator for the corner rotator.
// ----------------------------------------------------------------------------
package rcr_pkg;

  localparam int COORD_BITS_DEF     = 10;
  localparam int TRIG_FRAC_BITS_DEF = 14;
  localparam int ANGLE_BITS         = 10;
  localparam int OUT_BITS           = 12;
  localparam int OFFSET             = 50;
  localparam int QUARTER_ENTRIES    = 91;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Per-stage load enables for the rotate cells.
  typedef struct packed {
    logic prod;
    logic fin;
  } pipe_en_t;

  // sin(k degrees) with fb fraction bits; evaluated only at elaboration.
  // Series terms alternate in sign; each divisor is (2n)*(2n+1).
  function automatic longint unsigned quarter_sin(int unsigned k, int unsigned fb);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x    = (longint'(k) * PI_Q30 + 64'd90) / 64'd180;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd272; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd342; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd420; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd506; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd600; sum = sum + longint'(term);
    if (sum < 0) sum = 0;
    return (longint'(sum) + (64'd1 << (29 - fb))) >> (30 - fb);
  endfunction

endpackage

@@ sv/rcr_if.sv @@
// ----------------------------------------------------------------------------
// rcr_in_if / rcr_out_if
// Valid/ready channels carrying rectangle words and rotated corner words.
// ----------------------------------------------------------------------------
interface rcr_in_if import rcr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] angle_deg;
  logic        [COORD_BITS-1:0] left_x;
  logic        [COORD_BITS-1:0] top_y;
  logic        [COORD_BITS-1:0] right_x;
  logic        [COORD_BITS-1:0] bottom_y;

  modport source (output valid, angle_deg, left_x, top_y, right_x, bottom_y,
                  input ready);
  modport sink   (input valid, angle_deg, left_x, top_y, right_x, bottom_y,
                  output ready);
endinterface

interface rcr_out_if import rcr_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] corner_a_x;
  logic signed [OUT_BITS-1:0] corner_a_y;
  logic signed [OUT_BITS-1:0] corner_b_x;
  logic signed [OUT_BITS-1:0] corner_b_y;
  logic signed [OUT_BITS-1:0] corner_c_x;
  logic signed [OUT_BITS-1:0] corner_c_y;
  logic signed [OUT_BITS-1:0] corner_d_x;
  logic signed [OUT_BITS-1:0] corner_d_y;

  modport source (output valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
                  corner_c_x, corner_c_y, corner_d_x, corner_d_y, input ready);
  modport sink   (input valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
                  corner_c_x, corner_c_y, corner_d_x, corner_d_y, output ready);
endinterface

@@ sv/rectangle_corner_rotator_core.sv @@
// ----------------------------------------------------------------------------
// rectangle_corner_rotator_core
// Rotates the four corners of a rectangle by a whole-degree angle.
// ----------------------------------------------------------------------------
// One rectangle word enters per clock and one word of eight rotated corner
// coordinates leaves per clock while the output side takes words. The word
// passes four register stages: the angle is reduced mod 360 and registered
// with the rectangle, sine and cosine are read from a 91-entry quarter-wave
// constant table and registered, four identical rotate cells register the
// products, then add the offset of 50, truncate toward zero and saturate
// into the output register, where the result is offered. Every full stage
// holds when the one after it is full and stalled, so throughput is set
// only by the output side taking words.
module rectangle_corner_rotator_core import rcr_pkg::*; #(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  rcr_in_if.sink   in_bus,
  rcr_out_if.source out_bus
);
  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam logic signed [TW-1:0] ONE = TW'(1) <<< TRIG_FRAC_BITS;

  // stage valids and load enables
  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;
  pipe_en_t cell_en;

  assign en4 = !v4_r || out_bus.ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_bus.ready = en1;
  assign cell_en.prod = en3;
  assign cell_en.fin  = en4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_bus.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // stage 1: reduce angle into 0..359
  logic signed [ANGLE_BITS:0] ang_w;
  logic [8:0] a_r;
  logic [COORD_BITS-1:0] x1_r, y1_r, x2_r, y2_r;

  always_comb begin
    ang_w = (ANGLE_BITS+1)'(in_bus.angle_deg);
    if (ang_w < 0) ang_w = ang_w + 11'sd360;
    if (ang_w < 0) ang_w = ang_w + 11'sd360;
    if (ang_w >= 11'sd360) ang_w = ang_w - 11'sd360;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      a_r  <= ang_w[8:0];
      x1_r <= in_bus.left_x;
      y1_r <= in_bus.top_y;
      x2_r <= in_bus.right_x;
      y2_r <= in_bus.bottom_y;
    end
  end

  // stage 2: quarter-wave table lookup
  logic [TW-1:0] sin_tab [QUARTER_ENTRIES];
  for (genvar g = 0; g < QUARTER_ENTRIES; g++) begin : g_tab
    localparam logic [TW-1:0] V = TW'(quarter_sin(g, TRIG_FRAC_BITS));
    assign sin_tab[g] = V;
  end

  function automatic logic signed [TW-1:0] full_sin(logic [8:0] a,
                                                    logic [TW-1:0] t [QUARTER_ENTRIES]);
    logic [8:0] k;
    logic neg;
    if (a <= 9'd90)       begin k = a;          neg = 1'b0; end
    else if (a <= 9'd180) begin k = 9'd180 - a; neg = 1'b0; end
    else if (a <= 9'd270) begin k = a - 9'd180; neg = 1'b1; end
    else                  begin k = 9'd360 - a; neg = 1'b1; end
    return neg ? -$signed(t[k[6:0]]) : $signed(t[k[6:0]]);
  endfunction

  logic [8:0] b_w;
  logic signed [TW-1:0] s_r, c_r;
  logic [COORD_BITS-1:0] x1_2r, y1_2r, x2_2r, y2_2r;

  assign b_w = (a_r >= 9'd270) ? a_r - 9'd270 : a_r + 9'd90;

  always_ff @(posedge clk) begin
    if (en2) begin
      s_r   <= full_sin(a_r, sin_tab);
      c_r   <= full_sin(b_w, sin_tab);
      x1_2r <= x1_r;
      y1_2r <= y1_r;
      x2_2r <= x2_r;
      y2_2r <= y2_r;
    end
  end

  // stages 3 and 4: one rotate cell per corner
  rcr_rotate_cell #(.COORD_BITS(COORD_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cell_a (
    .clk(clk), .en(cell_en), .x(x1_2r), .y(y1_2r), .s(s_r), .c(c_r),
    .ox(out_bus.corner_a_x), .oy(out_bus.corner_a_y));
  rcr_rotate_cell #(.COORD_BITS(COORD_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cell_b (
    .clk(clk), .en(cell_en), .x(x2_2r), .y(y2_2r), .s(s_r), .c(c_r),
    .ox(out_bus.corner_b_x), .oy(out_bus.corner_b_y));
  rcr_rotate_cell #(.COORD_BITS(COORD_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cell_c (
    .clk(clk), .en(cell_en), .x(x1_2r), .y(y2_2r), .s(s_r), .c(c_r),
    .ox(out_bus.corner_c_x), .oy(out_bus.corner_c_y));
  rcr_rotate_cell #(.COORD_BITS(COORD_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cell_d (
    .clk(clk), .en(cell_en), .x(x2_2r), .y(y1_2r), .s(s_r), .c(c_r),
    .ox(out_bus.corner_d_x), .oy(out_bus.corner_d_y));

  assign out_bus.valid = v4_r;

  // input stalls only when every stage holds a word
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> (v1_r && v2_r && v3_r && v4_r))
    else $error("input stalled with a bubble in the pipeline");

  // a word in stage 3 moves to the output when it is free
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && en4) |=> v4_r)
    else $error("stage 3 word lost");

  // table output stays within +-1.0
  a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (s_r <= ONE && s_r >= -ONE && c_r <= ONE && c_r >= -ONE))
    else $error("sine or cosine out of range");
endmodule

@@ sv/rcr_rotate_cell.sv @@
// ----------------------------------------------------------------------------
// rcr_rotate_cell
// Rotates one corner: registered products, then offset, truncate, saturate.
// ----------------------------------------------------------------------------
module rcr_rotate_cell import rcr_pkg::*; #(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  pipe_en_t                       en,
  input  logic        [COORD_BITS-1:0]   x,
  input  logic        [COORD_BITS-1:0]   y,
  input  logic signed [TRIG_FRAC_BITS+1:0] s,
  input  logic signed [TRIG_FRAC_BITS+1:0] c,
  output logic signed [OUT_BITS-1:0]     ox,
  output logic signed [OUT_BITS-1:0]     oy
);
  localparam int TW    = TRIG_FRAC_BITS + 2;
  localparam int PW    = COORD_BITS + 1 + TW;
  localparam int SW    = COORD_BITS + TRIG_FRAC_BITS + 5;
  localparam int QW    = SW - TRIG_FRAC_BITS;
  localparam logic signed [SW-1:0] OFS  = SW'(OFFSET) <<< TRIG_FRAC_BITS;
  localparam logic signed [SW-1:0] BIAS = (SW'(1) <<< TRIG_FRAC_BITS) - SW'(1);
  localparam logic signed [QW-1:0] QMAX = QW'((1 << (OUT_BITS - 1)) - 1);
  localparam logic signed [QW-1:0] QMIN = -QW'(1 << (OUT_BITS - 1));

  logic signed [COORD_BITS:0] xs, ys;
  logic signed [PW-1:0] xc_r, ys_r, xs_r, yc_r;
  logic signed [OUT_BITS-1:0] ox_r, oy_r;

  assign xs = $signed({1'b0, x});
  assign ys = $signed({1'b0, y});

  function automatic logic signed [OUT_BITS-1:0] finish(logic signed [SW-1:0] acc);
    logic signed [SW-1:0] t;
    logic signed [QW-1:0] q;
    t = acc + OFS;
    if (t < 0) t = t + BIAS;
    q = QW'(t >>> TRIG_FRAC_BITS);
    if (q > QMAX) q = QMAX;
    if (q < QMIN) q = QMIN;
    return q[OUT_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en.prod) begin
      xc_r <= PW'(xs * c);
      ys_r <= PW'(ys * s);
      xs_r <= PW'(xs * s);
      yc_r <= PW'(ys * c);
    end
    if (en.fin) begin
      ox_r <= finish(SW'(xc_r) + SW'(ys_r));
      oy_r <= finish(SW'(yc_r) - SW'(xs_r));
    end
  end

  assign ox = ox_r;
  assign oy = oy_r;
endmodule
